FILE: rtl/rff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_pkg
// Shared widths, register codes, reset values and beat types of the
// radial force field block.
// ----------------------------------------------------------------------------
package rff_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int DIST_W    = 31;
	localparam int MODE_W    = 4;
	localparam int IDX_W     = 3;

	localparam int OFF_W   = DATA_W + 1;
	localparam int RAD_W   = 2 * OFF_W;
	localparam int ROOT_W  = OFF_W;
	localparam int NUM_W   = ROOT_W + FRAC_BITS;
	localparam int SQ_OP_W = (34 + 2 * FRAC_BITS) / 2;
	localparam int TE_W    = OFF_W + FRAC_BITS;
	localparam int TE_LO_W = TE_W / 2;
	localparam int DIFF_W  = DATA_W + 1;
	localparam int PROD_W  = DIFF_W + TE_W;
	localparam int P_W     = DIFF_W + 1;
	localparam int V_W     = P_W + 2;
	localparam int FN_W    = 2 * DATA_W;

	localparam logic [IDX_W-1:0] REG_MIN_DIST = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_DIST = 3'd1;
	localparam logic [IDX_W-1:0] REG_STR_MIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_STR_MAX  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd6;
	localparam logic [IDX_W-1:0] REG_MODE     = 3'd7;

	localparam logic [1:0] END_CLAMP = 2'd0;
	localparam logic [1:0] END_NONE  = 2'd1;
	localparam logic [1:0] END_CONT  = 2'd2;

	localparam int MODE_QUAD = 0;
	localparam int MODE_OUT  = 3;

	localparam logic [DIST_W-1:0] MIN_DIST_RST = DIST_W'(1) << FRAC_BITS;
	localparam logic [DIST_W-1:0] MAX_DIST_RST = DIST_W'(5) << FRAC_BITS;
	localparam logic [DATA_W-1:0] STR_MIN_RST  = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] STR_MAX_RST  = DATA_W'(5) << FRAC_BITS;

	typedef struct packed {
		logic signed [DATA_W-1:0] point_x;
		logic signed [DATA_W-1:0] point_y;
		logic signed [DATA_W-1:0] point_z;
	} pos_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic signed [DATA_W-1:0] force_z;
		logic        [DATA_W-1:0] radial_distance;
		logic signed [DATA_W-1:0] signed_strength;
		logic                     saturated;
		logic                     bad_limits;
	} res_t;

endpackage

FILE: rtl/rff_pos_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_pos_if
// Stream channel carrying one body position per beat.
// ----------------------------------------------------------------------------
interface rff_pos_if ();
	logic          valid;
	logic          ready;
	rff_pkg::pos_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rff_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_res_if
// Stream channel carrying one force result per beat.
// ----------------------------------------------------------------------------
interface rff_res_if ();
	logic          valid;
	logic          ready;
	rff_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rff_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_sqrt_cell
// One root bit of a restoring integer square root; takes two radicand bits
// and hands the partial root and remainder to the next cell.
// ----------------------------------------------------------------------------
module rff_sqrt_cell #(
	parameter int RAD_W  = rff_pkg::RAD_W,
	parameter int ROOT_W = rff_pkg::ROOT_W,
	parameter int SW     = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              cur_valid,
	input  logic [RAD_W-1:0]  cur_rad,
	input  logic [ROOT_W-1:0] cur_root,
	input  logic [ROOT_W+2:0] cur_rem,
	input  logic [SW-1:0]     cur_side,
	output logic              nxt_valid,
	output logic [RAD_W-1:0]  nxt_rad,
	output logic [ROOT_W-1:0] nxt_root,
	output logic [ROOT_W+2:0] nxt_rem,
	output logic [SW-1:0]     nxt_side
);
	localparam int REM_W = ROOT_W + 3;

	logic [REM_W-1:0] rin;
	logic [REM_W-1:0] trial;
	logic             ge;

	logic              valid_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [SW-1:0]     side_q;

	assign rin   = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
	assign trial = {1'b0, cur_root, 2'b01};
	assign ge    = rin >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {cur_rad[RAD_W-3:0], 2'b00};
			root_q <= {cur_root[ROOT_W-2:0], ge};
			rem_q  <= ge ? rin - trial : rin;
			side_q <= cur_side;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_rad   = rad_q;
	assign nxt_root  = root_q;
	assign nxt_rem   = rem_q;
	assign nxt_side  = side_q;
endmodule

FILE: rtl/rff_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_div_cell
// One quotient bit of restoring long division, over several lanes that
// share a divisor; quotient bits shift in as numerator bits shift out.
// ----------------------------------------------------------------------------
module rff_div_cell #(
	parameter int LANES = 1,
	parameter int DW    = rff_pkg::DIST_W,
	parameter int NW    = rff_pkg::NUM_W,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       cur_valid,
	input  logic [DW-1:0]              div,
	input  logic [LANES-1:0][DW-1:0]   cur_rem,
	input  logic [LANES-1:0][NW-1:0]   cur_num,
	input  logic [SW-1:0]              cur_side,
	output logic                       nxt_valid,
	output logic [LANES-1:0][DW-1:0]   nxt_rem,
	output logic [LANES-1:0][NW-1:0]   nxt_num,
	output logic [SW-1:0]              nxt_side
);
	logic [LANES-1:0][DW:0]   rin;
	logic [LANES-1:0][DW:0]   dif;
	logic [LANES-1:0]         ge;
	logic [LANES-1:0][DW-1:0] rem_d;
	logic [LANES-1:0][NW-1:0] num_d;

	logic                     valid_q;
	logic [LANES-1:0][DW-1:0] rem_q;
	logic [LANES-1:0][NW-1:0] num_q;
	logic [SW-1:0]            side_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rin[l]   = {cur_rem[l], cur_num[l][NW-1]};
			dif[l]   = rin[l] - {1'b0, div};
			ge[l]    = rin[l] >= {1'b0, div};
			rem_d[l] = ge[l] ? dif[l][DW-1:0] : rin[l][DW-1:0];
			num_d[l] = {cur_num[l][NW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_d;
			num_q  <= num_d;
			side_q <= cur_side;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_rem   = rem_q;
	assign nxt_num   = num_q;
	assign nxt_side  = side_q;
endmodule

FILE: rtl/radial_force_field_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_force_field_top
// Force of a point field on a streamed body position, Q16.16 throughout.
//
//   channel   dir  beat / write
//   pos       in   point_x, point_y, point_z
//   res       out  force_x/y/z, radial_distance, signed_strength, flags
//   wr_*      in   register index 0..7, data, one write per enabled edge
//
// One beat per cycle sustained; from accept to result a beat passes through
// 3 front stages, 33 root cells, 49 cells of the t divider, 7 strength
// stages, one product stage and 32 cells of the force divider, then a
// two-beat output skid. The cell chains set the latency.
// The pipeline freezes only while the skid holds two beats.
// Reset clears valid state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module radial_force_field_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [rff_pkg::IDX_W-1:0]  wr_index,
	input  logic [rff_pkg::DATA_W-1:0] wr_data,
	rff_pos_if.sink                    pos,
	rff_res_if.source                  res
);
	localparam int DATA_W  = rff_pkg::DATA_W;
	localparam int F       = rff_pkg::FRAC_BITS;
	localparam int DIST_W  = rff_pkg::DIST_W;
	localparam int OFF_W   = rff_pkg::OFF_W;
	localparam int RAD_W   = rff_pkg::RAD_W;
	localparam int ROOT_W  = rff_pkg::ROOT_W;
	localparam int NUM_W   = rff_pkg::NUM_W;
	localparam int SQ_OP_W = rff_pkg::SQ_OP_W;
	localparam int TE_W    = rff_pkg::TE_W;
	localparam int TE_LO_W = rff_pkg::TE_LO_W;
	localparam int DIFF_W  = rff_pkg::DIFF_W;
	localparam int PROD_W  = rff_pkg::PROD_W;
	localparam int P_W     = rff_pkg::P_W;
	localparam int V_W     = rff_pkg::V_W;
	localparam int FN_W    = rff_pkg::FN_W;
	localparam int QW      = FN_W - DATA_W;
	localparam int TSQ_W   = 2 * SQ_OP_W;

	localparam logic [NUM_W-1:0]  ONE_Q = NUM_W'(1) << F;
	localparam logic [P_W-1:0]    P_CAP = P_W'(1) << (P_W - 1);
	localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [2:0][OFF_W-1:0] mag;
		logic [2:0]            neg;
	} side_a_t;

	typedef struct packed {
		logic [2:0][OFF_W-1:0] mag;
		logic [2:0]            neg;
		logic [ROOT_W-1:0]     d;
	} side_b_t;

	typedef struct packed {
		logic [2:0]               fneg;
		logic signed [DATA_W-1:0] s;
		logic [ROOT_W-1:0]        d;
		logic                     flag;
	} side_c_t;

	// configuration
	logic [DIST_W-1:0]        min_q, max_q;
	logic signed [DATA_W-1:0] smin_q, smax_q;
	logic signed [DATA_W-1:0] cx_q, cy_q, cz_q;
	logic [rff_pkg::MODE_W-1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= rff_pkg::MIN_DIST_RST;
			max_q  <= rff_pkg::MAX_DIST_RST;
			smin_q <= rff_pkg::STR_MIN_RST;
			smax_q <= rff_pkg::STR_MAX_RST;
			cx_q   <= '0;
			cy_q   <= '0;
			cz_q   <= '0;
			mode_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				rff_pkg::REG_MIN_DIST: min_q  <= wr_data[DIST_W-1:0];
				rff_pkg::REG_MAX_DIST: max_q  <= wr_data[DIST_W-1:0];
				rff_pkg::REG_STR_MIN:  smin_q <= wr_data;
				rff_pkg::REG_STR_MAX:  smax_q <= wr_data;
				rff_pkg::REG_CENTER_X: cx_q   <= wr_data;
				rff_pkg::REG_CENTER_Y: cy_q   <= wr_data;
				rff_pkg::REG_CENTER_Z: cz_q   <= wr_data;
				rff_pkg::REG_MODE:     mode_q <= wr_data[rff_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [DIST_W-1:0]        span;
	logic                     bad;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        dmag;
	logic                     dneg, dzero;
	logic [1:0]               end_cond;

	assign span     = max_q - min_q;
	assign bad      = max_q <= min_q;
	assign diff     = {smax_q[DATA_W-1], smax_q} - {smin_q[DATA_W-1], smin_q};
	assign dneg     = diff[DIFF_W-1];
	assign dmag     = dneg ? DIFF_W'(-diff) : diff;
	assign dzero    = diff == '0;
	assign end_cond = mode_q[2:1];

	// pipeline enable and output skid
	logic [1:0] cnt_q;
	logic       en;
	assign en        = cnt_q != 2'd2;
	assign pos.ready = en;

	// s1: offsets
	logic                    v_s1;
	logic signed [OFF_W-1:0] off_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pos.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1[0] <= {pos.data.point_x[DATA_W-1], pos.data.point_x} - {cx_q[DATA_W-1], cx_q};
			off_s1[1] <= {pos.data.point_y[DATA_W-1], pos.data.point_y} - {cy_q[DATA_W-1], cy_q};
			off_s1[2] <= {pos.data.point_z[DATA_W-1], pos.data.point_z} - {cz_q[DATA_W-1], cz_q};
		end
	end

	// s2: magnitudes and squares
	logic             v_s2;
	side_a_t          sa_s2;
	logic [RAD_W-1:0] sq_s2 [3];
	side_a_t          sa_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sa_d.neg[i] = off_s1[i][OFF_W-1];
			sa_d.mag[i] = sa_d.neg[i] ? OFF_W'(-off_s1[i]) : off_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s2 <= sa_d;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= RAD_W'(sa_d.mag[i]) * RAD_W'(sa_d.mag[i]);
			end
		end
	end

	// s3: radicand
	logic             v_s3;
	side_a_t          sa_s3;
	logic [RAD_W-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s3  <= sa_s2;
			rad_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// square root chain
	logic [ROOT_W:0]   sq_valid;
	logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];
	logic [ROOT_W+2:0] sq_rem  [ROOT_W+1];
	side_a_t           sq_side [ROOT_W+1];

	assign sq_valid[0] = v_s3;
	assign sq_rad[0]   = rad_s3;
	assign sq_root[0]  = '0;
	assign sq_rem[0]   = '0;
	assign sq_side[0]  = sa_s3;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		rff_sqrt_cell #(
			.RAD_W (RAD_W),
			.ROOT_W(ROOT_W),
			.SW    ($bits(side_a_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cur_valid(sq_valid[k]),
			.cur_rad  (sq_rad[k]),
			.cur_root (sq_root[k]),
			.cur_rem  (sq_rem[k]),
			.cur_side (sq_side[k]),
			.nxt_valid(sq_valid[k+1]),
			.nxt_rad  (sq_rad[k+1]),
			.nxt_root (sq_root[k+1]),
			.nxt_rem  (sq_rem[k+1]),
			.nxt_side (sq_side[k+1])
		);
	end

	// t divider chain
	logic [ROOT_W-1:0] droot;
	logic [ROOT_W-1:0] dm;
	assign droot = sq_root[ROOT_W];
	assign dm    = droot - ROOT_W'(min_q);

	logic [NUM_W:0]             td_valid;
	logic [0:0][DIST_W-1:0]     td_rem  [NUM_W+1];
	logic [0:0][NUM_W-1:0]      td_num  [NUM_W+1];
	side_b_t                    td_side [NUM_W+1];

	assign td_valid[0]    = sq_valid[ROOT_W];
	assign td_rem[0]      = '0;
	assign td_num[0][0]   = {dm, F'(0)};
	assign td_side[0].mag = sq_side[ROOT_W].mag;
	assign td_side[0].neg = sq_side[ROOT_W].neg;
	assign td_side[0].d   = droot;

	for (genvar k = 0; k < NUM_W; k++) begin : g_tdiv
		rff_div_cell #(
			.LANES(1),
			.DW   (DIST_W),
			.NW   (NUM_W),
			.SW   ($bits(side_b_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cur_valid(td_valid[k]),
			.div      (span),
			.cur_rem  (td_rem[k]),
			.cur_num  (td_num[k]),
			.cur_side (td_side[k]),
			.nxt_valid(td_valid[k+1]),
			.nxt_rem  (td_rem[k+1]),
			.nxt_num  (td_num[k+1]),
			.nxt_side (td_side[k+1])
		);
	end

	// s4: clamp t, range tests
	logic             v_s4, zend_s4, below_s4;
	side_b_t          sb_s4;
	logic [NUM_W-1:0] t_s4;
	logic [NUM_W-1:0] traw;
	assign traw = td_num[NUM_W][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= td_valid[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4    <= td_side[NUM_W];
			t_s4     <= (end_cond != rff_pkg::END_CONT && traw > ONE_Q) ? ONE_Q : traw;
			zend_s4  <= end_cond == rff_pkg::END_NONE
				&& td_side[NUM_W].d > ROOT_W'(max_q);
			below_s4 <= td_side[NUM_W].d < ROOT_W'(min_q);
		end
	end

	// s5: t squared
	logic             v_s5, zend_s5, below_s5, tbig_s5;
	side_b_t          sb_s5;
	logic [NUM_W-1:0] t_s5;
	logic [TSQ_W-1:0] tsq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5    <= sb_s4;
			zend_s5  <= zend_s4;
			below_s5 <= below_s4;
			t_s5     <= t_s4;
			tbig_s5  <= |t_s4[NUM_W-1:SQ_OP_W];
			tsq_s5   <= TSQ_W'(t_s4[SQ_OP_W-1:0]) * TSQ_W'(t_s4[SQ_OP_W-1:0]);
		end
	end

	// s6: weight select and cap
	logic             v_s6, zend_s6, below_s6, thuge_s6;
	side_b_t          sb_s6;
	logic [TE_W-1:0]  te_s6;
	logic [TSQ_W-1:0] tqw;
	logic             quad;
	assign quad = mode_q[rff_pkg::MODE_QUAD];
	assign tqw  = quad ? (tsq_s5 >> F) : TSQ_W'(t_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6    <= sb_s5;
			zend_s6  <= zend_s5;
			below_s6 <= below_s5;
			te_s6    <= tqw[TE_W-1:0];
			thuge_s6 <= (quad & tbig_s5) | (|tqw[TSQ_W-1:TE_W]);
		end
	end

	// s7: partial products of the lerp
	logic                             v_s7, zend_s7, below_s7, thuge_s7;
	side_b_t                          sb_s7;
	logic [DIFF_W+TE_LO_W-1:0]        pl_s7;
	logic [DIFF_W+TE_W-TE_LO_W-1:0]   ph_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s7    <= sb_s6;
			zend_s7  <= zend_s6;
			below_s7 <= below_s6;
			thuge_s7 <= thuge_s6;
			pl_s7    <= (DIFF_W+TE_LO_W)'(dmag) * (DIFF_W+TE_LO_W)'(te_s6[TE_LO_W-1:0]);
			ph_s7    <= (DIFF_W+TE_W-TE_LO_W)'(dmag)
				* (DIFF_W+TE_W-TE_LO_W)'(te_s6[TE_W-1:TE_LO_W]);
		end
	end

	// s8: product sum, shift, cap
	logic              v_s8, zend_s8, below_s8;
	side_b_t           sb_s8;
	logic [P_W-1:0]    p_s8;
	logic [PROD_W-1:0] prod;
	logic              pbig;
	assign prod = {ph_s7, TE_LO_W'(0)} + PROD_W'(pl_s7);
	assign pbig = (thuge_s7 & ~dzero) | (|prod[PROD_W-1:F+P_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s8    <= sb_s7;
			zend_s8  <= zend_s7;
			below_s8 <= below_s7;
			p_s8     <= pbig ? P_CAP : {1'b0, prod[F+P_W-2:F]};
		end
	end

	// s9: lerp add, saturate, range select
	logic                     v_s9, sf_s9;
	side_b_t                  sb_s9;
	logic signed [DATA_W-1:0] st_s9;
	logic signed [V_W-1:0]    sminx, pe, lv;
	logic                     l_hi, l_lo;
	assign sminx = {{(V_W-DATA_W){smin_q[DATA_W-1]}}, smin_q};
	assign pe    = V_W'(p_s8);
	assign lv    = dneg ? sminx - pe : sminx + pe;
	assign l_hi  = !lv[V_W-1] && (|lv[V_W-2:DATA_W-1]);
	assign l_lo  = lv[V_W-1] && !(&lv[V_W-2:DATA_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s9 <= sb_s8;
			if (zend_s8) begin
				st_s9 <= '0;
				sf_s9 <= 1'b0;
			end else if (below_s8) begin
				st_s9 <= smin_q;
				sf_s9 <= 1'b0;
			end else begin
				st_s9 <= l_hi ? S_MAX : (l_lo ? S_MIN : lv[DATA_W-1:0]);
				sf_s9 <= l_hi | l_lo;
			end
		end
	end

	// s10: direction sign, bad limits
	logic                     v_s10, sf_s10;
	side_b_t                  sb_s10;
	logic signed [DATA_W-1:0] s_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s10 <= sb_s9;
			if (bad) begin
				s_s10  <= '0;
				sf_s10 <= 1'b0;
			end else if (!mode_q[rff_pkg::MODE_OUT]) begin
				s_s10  <= (st_s9 == S_MIN) ? S_MAX : -st_s9;
				sf_s10 <= sf_s9 | (st_s9 == S_MIN);
			end else begin
				s_s10  <= st_s9;
				sf_s10 <= sf_s9;
			end
		end
	end

	// s11: offset times strength
	logic              v_s11;
	side_c_t           sc_s11;
	logic [FN_W-1:0]   n_s11 [3];
	logic              sneg;
	logic [DATA_W-1:0] smag;
	assign sneg = s_s10[DATA_W-1];
	assign smag = sneg ? DATA_W'(-s_s10) : s_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s11.s    <= s_s10;
			sc_s11.d    <= sb_s10.d;
			sc_s11.flag <= sf_s10;
			for (int i = 0; i < 3; i++) begin
				sc_s11.fneg[i] <= sb_s10.neg[i] ^ sneg;
				n_s11[i]       <= FN_W'(sb_s10.mag[i]) * FN_W'(smag);
			end
		end
	end

	// force divider chain, one lane per axis
	logic [QW:0]                 fd_valid;
	logic [2:0][ROOT_W-1:0]      fd_rem  [QW+1];
	logic [2:0][QW-1:0]          fd_num  [QW+1];
	side_c_t                     fd_side [QW+1];

	assign fd_valid[0] = v_s11;
	assign fd_side[0]  = sc_s11;
	for (genvar i = 0; i < 3; i++) begin : g_fin
		assign fd_rem[0][i] = ROOT_W'(n_s11[i][FN_W-1:QW]);
		assign fd_num[0][i] = n_s11[i][QW-1:0];
	end

	for (genvar k = 0; k < QW; k++) begin : g_fdiv
		rff_div_cell #(
			.LANES(3),
			.DW   (ROOT_W),
			.NW   (QW),
			.SW   ($bits(side_c_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cur_valid(fd_valid[k]),
			.div      (fd_side[k].d),
			.cur_rem  (fd_rem[k]),
			.cur_num  (fd_num[k]),
			.cur_side (fd_side[k]),
			.nxt_valid(fd_valid[k+1]),
			.nxt_rem  (fd_rem[k+1]),
			.nxt_num  (fd_num[k+1]),
			.nxt_side (fd_side[k+1])
		);
	end

	// result assembly
	rff_pkg::res_t          nb;
	logic [2:0][DATA_W-1:0] fv;
	logic [2:0]             fsat;
	side_c_t                fs;
	logic                   fzero;
	logic [QW-1:0]          q;

	assign fs    = fd_side[QW];
	assign fzero = bad || (fs.d == '0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q       = fd_num[QW][i];
			fsat[i] = 1'b0;
			if (fzero) begin
				fv[i] = '0;
			end else if (fs.fneg[i]) begin
				fv[i] = DATA_W'(-q);
			end else if (q[QW-1]) begin
				fv[i]   = S_MAX;
				fsat[i] = 1'b1;
			end else begin
				fv[i] = DATA_W'(q);
			end
		end
		nb.force_x         = fv[0];
		nb.force_y         = fv[1];
		nb.force_z         = fv[2];
		nb.radial_distance = fs.d[ROOT_W-1] ? '1 : fs.d[DATA_W-1:0];
		nb.signed_strength = fs.s;
		nb.saturated       = fs.flag | (|fsat) | fs.d[ROOT_W-1];
		nb.bad_limits      = bad;
	end

	// output skid, two beats
	rff_pkg::res_t e0_q, e1_q;
	logic          push, pop;
	assign push = en && fd_valid[QW];
	assign pop  = (cnt_q != 2'd0) && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					e0_q <= nb;
				end else begin
					e1_q <= nb;
				end
			end
			2'b01: begin
				e0_q <= e1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					e0_q <= nb;
				end else begin
					e0_q <= e1_q;
					e1_q <= nb;
				end
			end
			default: ;
		endcase
	end

	assign res.valid = cnt_q != 2'd0;
	assign res.data  = e0_q;
endmodule
